[rtl/vdit_pkg.sv]
package vdit_pkg;

   localparam int MAX_VERTICES_DEFAULT = 256;
   localparam int WORDS_PER_VERTEX     = 8;

   typedef logic [31:0] word_type;
   typedef word_type [WORDS_PER_VERTEX-1:0] vertex_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_RESOLVE
   } state_type;

   function automatic logic word_is_nan(input word_type w);
      return (w[30:23] == 8'hFF) && (w[22:0] != 23'd0);
   endfunction

   function automatic logic words_float_equal(input word_type a, input word_type b);
      logic res;
      if (word_is_nan(a) || word_is_nan(b)) begin
         res = 1'b0;
      end else if (a == b) begin
         res = 1'b1;
      end else begin
         res = ((a[30:0] | b[30:0]) == 31'd0);
      end
      return res;
   endfunction

   function automatic logic vertex_equal(input vertex_type a, input vertex_type b);
      logic res;
      res = 1'b1;
      for (int k = 0; k < WORDS_PER_VERTEX; k++) begin
         res = res & words_float_equal(a[k], b[k]);
      end
      return res;
   endfunction

endpackage

[rtl/vdit_req_if.sv]
interface vdit_req_if;
   logic        valid;
   logic        ready;
   logic        first_of_mesh;
   logic [31:0] pos_x;
   logic [31:0] pos_y;
   logic [31:0] pos_z;
   logic [31:0] tex_u;
   logic [31:0] tex_v;
   logic [31:0] norm_x;
   logic [31:0] norm_y;
   logic [31:0] norm_z;

   modport source (output valid, first_of_mesh, pos_x, pos_y, pos_z, tex_u, tex_v,
                   norm_x, norm_y, norm_z, input ready);
   modport sink   (input valid, first_of_mesh, pos_x, pos_y, pos_z, tex_u, tex_v,
                   norm_x, norm_y, norm_z, output ready);
endinterface

[rtl/vdit_rsp_if.sv]
interface vdit_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] vertex_index;
   logic       is_new;
   logic       table_full;

   modport source (output valid, vertex_index, is_new, table_full, input ready);
   modport sink   (input valid, vertex_index, is_new, table_full, output ready);
endinterface

[rtl/vdit_cell.sv]
module vdit_cell (
   input  logic                 clock,
   input  logic                 write_en,
   input  logic                 compare_en,
   input  logic                 entry_valid,
   input  vdit_pkg::vertex_type key,
   output logic                 hit
);
   import vdit_pkg::*;

   vertex_type entry_ff;
   logic       hit_ff;
   logic       hit_in;

   assign hit_in = entry_valid && vertex_equal(entry_ff, key);

   always_ff @(posedge clock) begin
      if (write_en) begin
         entry_ff <= key;
      end
      if (compare_en) begin
         hit_ff <= hit_in;
      end
   end

   assign hit = hit_ff;

endmodule

[rtl/vertex_dedup_index_table.sv]
// Channel | Dir | Payload                                        | Transfer when
// req     | in  | first_of_mesh, pos_x..z, tex_u/v, norm_x..z    | req.valid && req.ready
// rsp     | out | vertex_index, is_new, table_full               | rsp.valid && rsp.ready
//
// An item passes through accept, parallel compare in every cell, then lowest-hit
// priority encode with append. Reset (synchronous) empties the table at once.
// A waiting result holds in the output register while the next item is taken;
// the resolve step stalls only when that register is still full.
module vertex_dedup_index_table #(
   parameter int MAX_VERTICES = vdit_pkg::MAX_VERTICES_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   vdit_req_if.sink  req,
   vdit_rsp_if.source rsp
);
   import vdit_pkg::*;

   localparam int CountWidth = $clog2(MAX_VERTICES + 1);
   localparam int IndexWidth = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

   state_type             state_ff, state_in;
   vertex_type            key_ff;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            index_out_ff, index_out_in;
   logic                  is_new_ff, is_new_in;
   logic                  full_ff, full_in;

   logic                    accept;
   logic                    compare_en;
   logic                    resolve_go;
   logic                    append;
   logic [MAX_VERTICES-1:0] hits;
   logic [MAX_VERTICES-1:0] write_en;
   logic                    found;
   logic [IndexWidth-1:0]   found_idx;
   logic [IndexWidth-1:0]   append_idx;
   logic                    room;

   assign accept     = req.valid && req.ready;
   assign compare_en = (state_ff == ST_COMPARE);
   assign resolve_go = (state_ff == ST_RESOLVE) && (!rsp_valid_ff || rsp.ready);
   assign room       = (count_ff < CountWidth'(MAX_VERTICES));
   assign append     = resolve_go && !found && room;
   assign append_idx = count_ff[IndexWidth-1:0];

   // one cell per table entry; key broadcast, hit registered in the cell
   for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
      assign write_en[i] = append && (append_idx == IndexWidth'(i));
      vdit_cell u_cell (
         .clock       (clock),
         .write_en    (write_en[i]),
         .compare_en  (compare_en),
         .entry_valid (CountWidth'(i) < count_ff),
         .key         (key_ff),
         .hit         (hits[i])
      );
   end

   // lowest hit wins: scan from the top so the last assignment is the lowest
   always_comb begin
      found     = 1'b0;
      found_idx = '0;
      for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
         if (hits[i]) begin
            found     = 1'b1;
            found_idx = IndexWidth'(i);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (accept)     state_in = ST_COMPARE;
         ST_COMPARE:                  state_in = ST_RESOLVE;
         ST_RESOLVE:  if (resolve_go) state_in = ST_IDLE;
         default:                     state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      index_out_in = index_out_ff;
      is_new_in    = is_new_ff;
      full_in      = full_ff;
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      // drop the table ahead of the first vertex of a mesh
      if (accept && req.first_of_mesh) begin
         count_in = '0;
      end
      if (resolve_go) begin
         rsp_valid_in = 1'b1;
         priority if (found) begin
            index_out_in = 8'(found_idx);
            is_new_in    = 1'b0;
            full_in      = 1'b0;
         end else if (room) begin
            index_out_in = 8'(append_idx);
            is_new_in    = 1'b1;
            full_in      = 1'b0;
            count_in     = count_ff + 1'b1;
         end else begin
            index_out_in = '0;
            is_new_in    = 1'b0;
            full_in      = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff <= {req.norm_z, req.norm_y, req.norm_x, req.tex_v,
                    req.tex_u, req.pos_z, req.pos_y, req.pos_x};
      end
      index_out_ff <= index_out_in;
      is_new_ff    <= is_new_in;
      full_ff      <= full_in;
   end

   assign req.ready        = (state_ff == ST_IDLE);
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.vertex_index = index_out_ff;
   assign rsp.is_new       = is_new_ff;
   assign rsp.table_full   = full_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(MAX_VERTICES))
      else $error("entry count beyond table size");

   a_new_full_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(is_new_ff && full_ff))
      else $error("result both new and full");

   a_full_index_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && full_ff) |-> (index_out_ff == 8'd0))
      else $error("full result with nonzero index");

   a_append_counts: assert property (@(posedge clock) disable iff (reset)
      append |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("append did not advance count");

endmodule

[test/tb_top.sv]
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import vdit_pkg::*;

   typedef struct packed {
      logic       first_of_mesh;
      vertex_type words;
   } vertex_item_type;

   typedef struct packed {
      logic [7:0] vertex_index;
      logic       is_new;
      logic       table_full;
   } index_result_type;

   localparam int TABLE_DEPTH = MAX_VERTICES_DEFAULT;
   localparam int HOLD_CYCLES = 300;

   logic clock;
   logic reset;

   vdit_req_if req ();
   vdit_rsp_if rsp ();

   vertex_dedup_index_table i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   // Shadow copy of the unique-vertex table, updated as each transfer is taken.
   vertex_type       shadow_table [TABLE_DEPTH];
   int unsigned      shadow_count;
   index_result_type expected_indices [$];
   int unsigned      mismatch_count;

   // Idle percentages of the current phase.
   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;

   // The hold request is a counter owned by the stimulus; the receiver owns the rest.
   int unsigned hold_ask;
   int unsigned hold_seen;
   int unsigned hold_left;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------
   function automatic logic word_nan(input word_type w);
      return (w[30:23] == 8'hFF) && (w[22:0] != 23'd0);
   endfunction

   // Float equality: NaN never equal, zeros of either sign equal.
   function automatic logic word_same_value(input word_type a, input word_type b);
      if (word_nan(a) || word_nan(b)) return 1'b0;
      return (a == b) || ({a[30:0], b[30:0]} == 62'd0);
   endfunction

   function automatic index_result_type lookup_or_append(input vertex_item_type item);
      index_result_type res;
      logic             hit;
      if (item.first_of_mesh) shadow_count = 0;
      res = '0;
      for (int e = 0; e < shadow_count; e++) begin
         hit = 1'b1;
         for (int k = 0; k < WORDS_PER_VERTEX; k++)
            hit &= word_same_value(shadow_table[e][k], item.words[k]);
         if (hit) begin
            res.vertex_index = e[7:0];
            return res;
         end
      end
      if (shadow_count >= TABLE_DEPTH) begin
         // No match and no room: drop the vertex, flag the table as full.
         res.table_full = 1'b1;
         return res;
      end
      shadow_table[shadow_count] = item.words;
      res.vertex_index = shadow_count[7:0];
      res.is_new = 1'b1;
      shadow_count++;
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string what, input int unsigned want,
                                  input int unsigned got);
      $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
      mismatch_count++;
   endtask

   // Compare every result transfer with the oldest waiting expectation.
   always @(posedge clock) begin
      index_result_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_indices.size() == 0) begin
            report_mismatch("unexpected result, queue depth", 0, 1);
         end else begin
            want = expected_indices.pop_front();
            if (rsp.vertex_index !== want.vertex_index)
               report_mismatch("vertex_index", 32'(want.vertex_index),
                               32'(rsp.vertex_index));
            if (rsp.is_new !== want.is_new)
               report_mismatch("is_new", 32'(want.is_new), 32'(rsp.is_new));
            if (rsp.table_full !== want.table_full)
               report_mismatch("table_full", 32'(want.table_full), 32'(rsp.table_full));
         end
      end
   end

   // Receiver: random stalls, or a long hold-off when one is asked for.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_ask != hold_seen) begin
         hold_seen <= hold_ask;
         hold_left <= HOLD_CYCLES;
         rsp.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   // Offer one vertex, hold it until the transfer, then predict its result.
   task automatic send_vertex(input vertex_item_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid         <= 1'b1;
      req.first_of_mesh <= item.first_of_mesh;
      req.pos_x         <= item.words[0];
      req.pos_y         <= item.words[1];
      req.pos_z         <= item.words[2];
      req.tex_u         <= item.words[3];
      req.tex_v         <= item.words[4];
      req.norm_x        <= item.words[5];
      req.norm_y        <= item.words[6];
      req.norm_z        <= item.words[7];
      do @(posedge clock); while (!req.ready);
      expected_indices.insert(expected_indices.size(), lookup_or_append(item));
   endtask

   // Drop valid and hold until every expected result has been taken.
   task automatic wait_all_results();
      req.valid <= 1'b0;
      while (expected_indices.size() != 0) @(posedge clock);
   endtask

   task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   // Mostly the interesting float patterns, with a share of fully random words.
   function automatic word_type pick_word();
      case ($urandom_range(9))
         0:       return 32'h0000_0000;
         1:       return 32'h8000_0000;
         2:       return 32'h7F80_0000;
         3:       return 32'hFF80_0000;
         4:       return 32'h7FC0_0000 | $urandom_range(3);
         5:       return 32'h3F80_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic vertex_type random_vertex();
      vertex_type v;
      for (int k = 0; k < WORDS_PER_VERTEX; k++) v[k] = pick_word();
      return v;
   endfunction

   // Randomly flip the sign of zero words so a match must see through it.
   function automatic vertex_type flip_zero_signs(input vertex_type v);
      for (int k = 0; k < WORDS_PER_VERTEX; k++)
         if (v[k][30:0] == 31'd0 && $urandom_range(1)) v[k][31] = ~v[k][31];
      return v;
   endfunction

   function automatic vertex_item_type as_item(input logic first, input vertex_type v);
      vertex_item_type it;
      it.first_of_mesh = first;
      it.words         = v;
      return it;
   endfunction

   task automatic test_float_equality();
      vertex_type base;
      vertex_type zeros;
      vertex_type nan_vertex;
      base       = random_vertex();
      base[2]    = 32'h0000_0000;
      base[6]    = 32'h8000_0000;
      for (int k = 0; k < WORDS_PER_VERTEX; k++) base[k] = word_nan(base[k]) ? 32'h0 : base[k];
      zeros      = '0;
      nan_vertex = base;
      nan_vertex[4] = 32'h7FC0_0000;
      send_vertex(as_item(1'b1, base));
      send_vertex(as_item(1'b0, base));
      // Zero words with opposite signs still match.
      base[2] = 32'h8000_0000;
      base[6] = 32'h0000_0000;
      send_vertex(as_item(1'b0, base));
      send_vertex(as_item(1'b0, nan_vertex));
      send_vertex(as_item(1'b0, nan_vertex));
      send_vertex(as_item(1'b0, zeros));
      send_vertex(as_item(1'b0, '1));
      send_vertex(as_item(1'b0, {8{32'h7F80_0000}}));
      send_vertex(as_item(1'b0, {8{32'hFF80_0000}}));
      send_vertex(as_item(1'b0, {8{32'h7FFF_FFFF}}));
      send_vertex(as_item(1'b0, {8{32'h8000_0000}}));
      send_vertex(as_item(1'b0, {8{32'h7F80_0000}}));
      // Empty the table: the old vertex becomes new again at index 0.
      send_vertex(as_item(1'b1, zeros));
      send_vertex(as_item(1'b0, base));
      send_vertex(as_item(1'b1, base));
      wait_all_results();
   endtask

   // Fill every entry, overflow, then mix hits on existing entries with misses while full.
   task automatic test_table_full();
      vertex_type v;
      for (int i = 0; i < TABLE_DEPTH + 4; i++) begin
         v    = random_vertex();
         v[0] = i;
         send_vertex(as_item(i == 0, v));
      end
      for (int i = 0; i < 8; i++) begin
         v    = '0;
         v[0] = $urandom_range(TABLE_DEPTH - 1);
         v[1] = $urandom;
         send_vertex(as_item(1'b0, ($urandom_range(1) ? shadow_table[v[0]] : v)));
      end
      wait_all_results();
   endtask

   // Block the result side for a long stretch while the sender keeps offering.
   task automatic test_result_backpressure();
      hold_ask++;
      for (int i = 0; i < 30; i++)
         send_vertex(as_item(i == 0, random_vertex()));
      wait_all_results();
   endtask

   // Meshes drawn from a small vertex pool, with noise and stray table resets mixed in.
   task automatic test_random_meshes(input int unsigned item_total);
      vertex_type  mesh_pool [$];
      int unsigned sent;
      int unsigned mesh_len;
      vertex_type  v;
      logic        first;
      sent = 0;
      while (sent < item_total) begin
         mesh_pool.delete();
         repeat ($urandom_range(1, 24)) mesh_pool.insert(mesh_pool.size(), random_vertex());
         mesh_len = $urandom_range(4, 80);
         for (int i = 0; i < mesh_len && sent < item_total; i++) begin
            first = (i == 0) || ($urandom_range(49) == 0);
            case ($urandom_range(9))
               0:       v = random_vertex();
               1, 2:    v = flip_zero_signs(mesh_pool[$urandom_range(mesh_pool.size() - 1)]);
               default: v = mesh_pool[$urandom_range(mesh_pool.size() - 1)];
            endcase
            send_vertex(as_item(first, v));
            sent++;
         end
      end
      wait_all_results();
   endtask

   initial begin
      reset             = 1'b1;
      req.valid         = 1'b0;
      req.first_of_mesh = 1'b0;
      req.pos_x         = '0;
      req.pos_y         = '0;
      req.pos_z         = '0;
      req.tex_u         = '0;
      req.tex_v         = '0;
      req.norm_x        = '0;
      req.norm_y        = '0;
      req.norm_z        = '0;
      shadow_count      = 0;
      hold_ask          = 0;
      set_idling(0, 0);
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_float_equality();
      test_table_full();
      set_idling(9, 9);
      test_result_backpressure();

      set_idling(0, 0);
      test_random_meshes(420);
      set_idling(84, 0);
      test_random_meshes(420);
      set_idling(0, 84);
      test_random_meshes(420);
      set_idling(9, 9);
      test_random_meshes(420);

      // Let the pipeline settle in case anything is still on its way.
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_indices.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #8ms;
      $display("status: fail");
      $finish;
   end

endmodule

[files.f]
rtl/vdit_pkg.sv
rtl/vdit_req_if.sv
rtl/vdit_rsp_if.sv
rtl/vdit_cell.sv
rtl/vertex_dedup_index_table.sv
test/tb_top.sv
